FILE: hdl/vna_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vna_pkg - shared types and constants
// Item formats, command format between front and back, opcodes, status codes
// and the back-end sequencer states of the vertex normal accumulator.
// -----------------------------------------------------------------------------
package vna_pkg;

  // sizes
  localparam int VIDX_W   = 10;
  localparam int CNT_W    = VIDX_W + 1;
  localparam int NUM_VERT = 1 << VIDX_W;
  localparam int CRD_W    = 16;
  localparam int POS_W    = 3 * CRD_W;
  localparam int EDGE_W   = CRD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int ACC_W    = 48;
  localparam int ACCW_W   = 3 * ACC_W;
  localparam int MAG_W    = 30;
  localparam int SQ_W     = 2 * MAG_W + 2;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int NRM_W    = 16;
  localparam int FRAC_W   = 14;
  localparam int QUO_W    = 16;
  localparam int DIV_W    = 48;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(1 << FRAC_W);

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PRD, S_EDGE, S_MUL, S_ARD, S_AWR, S_RRD, S_RMAG,
    S_SHIFT, S_SQ, S_SQRT, S_DIVINIT, S_DIV, S_DSTORE, S_EMIT
  } bstate_e;

  typedef struct packed {
    op_e                     opcode;
    logic [VIDX_W-1:0]       vertex_index;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;
    logic [VIDX_W-1:0]       corner_a;
    logic [VIDX_W-1:0]       corner_b;
    logic [VIDX_W-1:0]       corner_c;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]       normal_vertex;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    status_e                 status;
  } out_item_t;

  // classified command; vertex holds the offending index when bad is set
  typedef struct packed {
    op_e               op;
    logic              bad;
    logic [VIDX_W-1:0] vertex;
    logic [POS_W-1:0]  pos;
    logic [VIDX_W-1:0] corner_a;
    logic [VIDX_W-1:0] corner_b;
    logic [VIDX_W-1:0] corner_c;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/vna_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vna_front - input stage
// Holds the vertex count register, range-checks indices and turns each input
// transfer into a command for the queue.
// -----------------------------------------------------------------------------
module vna_front import vna_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             init_done_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [CNT_W-1:0] vcount_q;
  logic ok_v, ok_a, ok_b, ok_c;

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  assign ok_v = {1'b0, in_data_i.vertex_index} < vcount_q;
  assign ok_a = {1'b0, in_data_i.corner_a} < vcount_q;
  assign ok_b = {1'b0, in_data_i.corner_b} < vcount_q;
  assign ok_c = {1'b0, in_data_i.corner_c} < vcount_q;

  // classify
  always_comb begin
    cmd_o.op       = in_data_i.opcode;
    cmd_o.pos      = {in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
    cmd_o.corner_a = in_data_i.corner_a;
    cmd_o.corner_b = in_data_i.corner_b;
    cmd_o.corner_c = in_data_i.corner_c;
    cmd_o.vertex   = in_data_i.vertex_index;
    cmd_o.bad      = 1'b0;
    unique case (in_data_i.opcode)
      OP_WRITE, OP_READ: begin
        cmd_o.bad = !ok_v;
      end
      OP_TRIANGLE: begin
        cmd_o.bad = !(ok_a && ok_b && ok_c);
        if (!ok_a) begin
          cmd_o.vertex = in_data_i.corner_a;
        end else if (!ok_b) begin
          cmd_o.vertex = in_data_i.corner_b;
        end else begin
          cmd_o.vertex = in_data_i.corner_c;
        end
      end
      default: begin
        cmd_o.bad = 1'b0;
      end
    endcase
  end

  assign in_ready_o = init_done_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule
`default_nettype wire

FILE: hdl/vna_queue.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vna_queue - command queue
// Short FIFO between the front and back so either side can stall alone.
// -----------------------------------------------------------------------------
module vna_queue import vna_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

  assign cmd_o   = slot_q[rptr_q];
  assign full_o  = count_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = count_q == '0;

endmodule
`default_nettype wire

FILE: hdl/vna_back.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vna_back - execution sequencer
// Owns the position and accumulator memories; runs vertex writes, triangle adds,
// clears and reads (shift, sum of squares, bit-serial root, shift-subtract divide).
// -----------------------------------------------------------------------------
module vna_back import vna_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire cmd_t q_cmd_i,
  output logic      pop_o,
  output logic      init_done_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_data_o
);

  bstate_e            state_q, state_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [4:0]         step_q, step_d;
  logic [VIDX_W-1:0]  clr_addr_q, clr_addr_d;
  logic               init_done_q, init_done_d;
  logic               out_valid_q;
  out_item_t          out_q;
  logic               out_load;

  // memories
  logic [POS_W-1:0]   pos_mem [NUM_VERT];
  logic [ACCW_W-1:0]  acc_mem [NUM_VERT];
  logic               pos_we, pos_re, acc_we, acc_re;
  logic [VIDX_W-1:0]  pos_waddr, pos_raddr, acc_waddr, acc_raddr;
  logic [POS_W-1:0]   pos_wdata, pos_rdata_q;
  logic [ACCW_W-1:0]  acc_wdata, acc_rdata_q;

  // datapath
  cmd_t                      cmd_q;
  logic [POS_W-1:0]          vpos_q [3];
  logic signed [EDGE_W-1:0]  d1x_q, d1y_q, d1z_q, d2x_q, d2y_q, d2z_q;
  logic signed [EDGE_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [CROSS_W-1:0] prod_x;
  logic signed [CROSS_W-1:0] crx_q, cry_q, crz_q;
  logic [ACC_W-1:0]          mag_q [3];
  logic [2:0]                neg_q;
  logic [SQ_W-1:0]           sum_q;
  logic [MAG_W-1:0]          sq_in;
  logic [2*MAG_W-1:0]        sq_prod;
  logic [REM_W-1:0]          rem_q, rem_sh, trial;
  logic [ROOT_W-1:0]         root_q;
  logic [DIV_W-1:0]          dnum_q, dden_q;
  logic [QUO_W-1:0]          quo_q, quo_c;
  logic signed [NRM_W-1:0]   nrm_q [3];
  out_item_t                 res_q;
  logic [ACC_W-1:0]          sat_x, sat_y, sat_z;
  logic [VIDX_W-1:0]         corner;
  logic                      acc_zero;

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc,
                                               logic signed [CROSS_W-1:0] add);
    logic [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(add);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic [ACC_W-1:0] magn(logic [ACC_W-1:0] v);
    magn = v[ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  // corner picked by the counter
  always_comb begin
    case (cnt_q)
      2'd0:    corner = cmd_q.corner_a;
      2'd1:    corner = cmd_q.corner_b;
      default: corner = cmd_q.corner_c;
    endcase
  end

  assign sat_x = sat_add(acc_rdata_q[3*ACC_W-1:2*ACC_W], crx_q);
  assign sat_y = sat_add(acc_rdata_q[2*ACC_W-1:ACC_W], cry_q);
  assign sat_z = sat_add(acc_rdata_q[ACC_W-1:0], crz_q);
  assign acc_zero = acc_rdata_q == '0;

  // shared cross product multiplier
  always_comb begin
    case (step_q[2:0])
      3'd0:    begin mul_a = d1y_q; mul_b = d2z_q; end
      3'd1:    begin mul_a = d1z_q; mul_b = d2y_q; end
      3'd2:    begin mul_a = d1z_q; mul_b = d2x_q; end
      3'd3:    begin mul_a = d1x_q; mul_b = d2z_q; end
      3'd4:    begin mul_a = d1x_q; mul_b = d2y_q; end
      default: begin mul_a = d1y_q; mul_b = d2x_q; end
    endcase
  end
  assign prod   = mul_a * mul_b;
  assign prod_x = CROSS_W'(prod);

  // squarer, full width product
  assign sq_in   = mag_q[step_q[1:0]][MAG_W-1:0];
  assign sq_prod = sq_in * sq_in;

  // square root step
  assign rem_sh = {rem_q[REM_W-3:0], sum_q[SQ_W-1:SQ_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign quo_c  = (quo_q > ONE_Q14) ? ONE_Q14 : quo_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    clr_addr_d  = clr_addr_q;
    init_done_d = init_done_q;
    pop_o       = 1'b0;
    pos_we      = 1'b0;
    pos_re      = 1'b0;
    acc_we      = 1'b0;
    acc_re      = 1'b0;
    pos_waddr   = q_cmd_i.vertex;
    pos_wdata   = q_cmd_i.pos;
    pos_raddr   = corner;
    acc_waddr   = corner;
    acc_wdata   = {sat_x, sat_y, sat_z};
    acc_raddr   = corner;
    out_load    = 1'b0;
    unique case (state_q)
      S_CLR: begin
        acc_we     = 1'b1;
        acc_waddr  = clr_addr_q;
        acc_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == VIDX_W'(NUM_VERT - 1)) begin
          init_done_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          cnt_d = '0;
          if (q_cmd_i.bad) begin
            state_d = S_EMIT;
          end else begin
            unique case (q_cmd_i.op)
              OP_WRITE:    pos_we  = 1'b1;
              OP_TRIANGLE: state_d = S_PRD;
              OP_CLEAR:    state_d = S_CLR;
              default:     state_d = S_RRD;
            endcase
          end
        end
      end
      S_PRD: begin
        pos_re = cnt_q != 2'd3;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 2'd3) state_d = S_EDGE;
      end
      S_EDGE: begin
        step_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 5'd5) begin
          cnt_d   = '0;
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        acc_re  = 1'b1;
        state_d = S_AWR;
      end
      S_AWR: begin
        acc_we  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = (cnt_q == 2'd2) ? S_IDLE : S_ARD;
      end
      S_RRD: begin
        acc_re    = 1'b1;
        acc_raddr = cmd_q.vertex;
        state_d   = S_RMAG;
      end
      S_RMAG: begin
        state_d = acc_zero ? S_EMIT : S_SHIFT;
      end
      S_SHIFT: begin
        if ((mag_q[0] | mag_q[1] | mag_q[2]) < ACC_W'(1 << MAG_W)) begin
          step_d  = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        step_d = step_q + 1'b1;
        if (step_q == 5'd2) begin
          step_d  = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        step_d = step_q + 1'b1;
        if (step_q == 5'(ROOT_W - 1)) begin
          cnt_d   = '0;
          state_d = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == 5'(QUO_W - 1)) state_d = S_DSTORE;
      end
      S_DSTORE: begin
        cnt_d   = cnt_q + 1'b1;
        state_d = (cnt_q == 2'd2) ? S_EMIT : S_DIVINIT;
      end
      S_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      step_q      <= '0;
      clr_addr_q  <= '0;
      init_done_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      clr_addr_q  <= clr_addr_d;
      init_done_q <= init_done_d;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (pos_re) pos_rdata_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) acc_rdata_q <= acc_mem[acc_raddr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= q_cmd_i;
        res_q <= '{normal_vertex: q_cmd_i.vertex, normal_x: '0, normal_y: '0,
                   normal_z: '0, status: ST_RANGE};
      end
      S_PRD: begin
        if (cnt_q != 2'd0) vpos_q[cnt_q - 1'b1] <= pos_rdata_q;
      end
      S_EDGE: begin
        d1x_q <= EDGE_W'($signed(vpos_q[1][47:32])) - EDGE_W'($signed(vpos_q[0][47:32]));
        d1y_q <= EDGE_W'($signed(vpos_q[1][31:16])) - EDGE_W'($signed(vpos_q[0][31:16]));
        d1z_q <= EDGE_W'($signed(vpos_q[1][15:0]))  - EDGE_W'($signed(vpos_q[0][15:0]));
        d2x_q <= EDGE_W'($signed(vpos_q[2][47:32])) - EDGE_W'($signed(vpos_q[0][47:32]));
        d2y_q <= EDGE_W'($signed(vpos_q[2][31:16])) - EDGE_W'($signed(vpos_q[0][31:16]));
        d2z_q <= EDGE_W'($signed(vpos_q[2][15:0]))  - EDGE_W'($signed(vpos_q[0][15:0]));
      end
      S_MUL: begin
        case (step_q[2:0])
          3'd0:    crx_q <= prod_x;
          3'd1:    crx_q <= crx_q - prod_x;
          3'd2:    cry_q <= prod_x;
          3'd3:    cry_q <= cry_q - prod_x;
          3'd4:    crz_q <= prod_x;
          default: crz_q <= crz_q - prod_x;
        endcase
      end
      S_RMAG: begin
        mag_q[0] <= magn(acc_rdata_q[3*ACC_W-1:2*ACC_W]);
        mag_q[1] <= magn(acc_rdata_q[2*ACC_W-1:ACC_W]);
        mag_q[2] <= magn(acc_rdata_q[ACC_W-1:0]);
        neg_q    <= {acc_rdata_q[ACC_W-1], acc_rdata_q[2*ACC_W-1],
                     acc_rdata_q[3*ACC_W-1]};
        sum_q    <= '0;
        res_q    <= '{normal_vertex: cmd_q.vertex, normal_x: ONE_Q14, normal_y: '0,
                      normal_z: '0, status: ST_ZERO_LEN};
      end
      S_SHIFT: begin
        if ((mag_q[0] | mag_q[1] | mag_q[2]) >= ACC_W'(1 << MAG_W)) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end
      end
      S_SQ: begin
        sum_q  <= sum_q + SQ_W'(sq_prod);
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        sum_q <= sum_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      S_DIVINIT: begin
        dnum_q <= (DIV_W'(mag_q[cnt_q][MAG_W-1:0]) << FRAC_W) + DIV_W'(root_q >> 1);
        dden_q <= DIV_W'(root_q) << (QUO_W - 1);
        quo_q  <= '0;
      end
      S_DIV: begin
        dden_q <= dden_q >> 1;
        if (dnum_q >= dden_q) begin
          dnum_q <= dnum_q - dden_q;
          quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      S_DSTORE: begin
        nrm_q[cnt_q] <= neg_q[cnt_q] ? -$signed(quo_c) : $signed(quo_c);
        if (cnt_q == 2'd2) begin
          res_q <= '{normal_vertex: cmd_q.vertex, normal_x: nrm_q[0],
                     normal_y: nrm_q[1],
                     normal_z: neg_q[2] ? -$signed(quo_c) : $signed(quo_c),
                     status: ST_VALID};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign init_done_o = init_done_q;

  // checks
  a_acc_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> (state_q == S_AWR || state_q == S_CLR))
    else $error("accumulator write outside add or clear");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE && init_done_q))
    else $error("command taken while busy");
  a_root_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVINIT) |-> (root_q != '0))
    else $error("zero root reached divider");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: hdl/vertex_normal_accumulator.sv
`default_nettype none
// Throughput: one item at a time in the back end; reads are set by the bit-serial
// root and the shared shift-subtract divider, triangles by the shared multiplier.
// Reset: a pass over all 1024 accumulator entries zeroes them; no input transfer until it ends.
// Configuration writes load a registered vertex count used by the range checks.
// -----------------------------------------------------------------------------
// vertex_normal_accumulator - area weighted vertex normals
// Front classifies items, a short queue decouples it from the back end,
// which updates the stores and produces unit normals in Q1.14.
// -----------------------------------------------------------------------------
module vertex_normal_accumulator import vna_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  cmd_t f_cmd, q_cmd;
  logic push, pop, q_full, q_empty, init_done;

  vna_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .cfg_we_i, .cfg_wdata_i,
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (f_cmd)
  );

  vna_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (f_cmd),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vna_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
